// ===== rtl/core/lfk_pkg.sv =====
// shared types, constants and helper functions of the leg forward kinematics block
// no dependencies; used by lfk_cordic and leg_forward_kinematics
`default_nettype none

package lfk_pkg;

  localparam int TURN_W  = 32;     // binary angle scaled to a 32-bit turn
  localparam int SC_W    = 20;     // sine/cosine width, q16 plus headroom
  localparam int Z_W     = 34;     // residual angle width
  localparam int LEN_W   = 15;
  localparam int OUT_W   = 18;
  localparam int IN_W    = 16;
  localparam int GAIN_Q16 = 39797;

  localparam logic [1:0] REG_BASE  = 2'd0;
  localparam logic [1:0] REG_UPPER = 2'd1;
  localparam logic [1:0] REG_LOWER = 2'd2;

  typedef logic signed [SC_W-1:0] sc_t;

  // atan(2^-i) in 2^32-per-turn units
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] r;
    case (i)
      0:  r = 32'd536870912;
      1:  r = 32'd316933406;
      2:  r = 32'd167458907;
      3:  r = 32'd85004756;
      4:  r = 32'd42667331;
      5:  r = 32'd21354465;
      6:  r = 32'd10679838;
      7:  r = 32'd5340245;
      8:  r = 32'd2670163;
      9:  r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // clamp a rounded value to the 18-bit output range
  function automatic logic [OUT_W-1:0] sat_out(input logic signed [31:0] v);
    logic [OUT_W-1:0] r;
    if (v > 32'sd131071) begin
      r = 18'h1FFFF;
    end else if (v < -32'sd131072) begin
      r = 18'h20000;
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lfk_cordic.sv =====
// fully pipelined rotation-mode cordic giving sine and cosine in q16
// depends on lfk_pkg; registered input and output around the iteration stages, one angle per cycle
`default_nettype none

module lfk_cordic #(
  parameter int STAGES = 16
) (
  input  wire logic                          clk,
  input  wire logic [lfk_pkg::TURN_W-1:0]    angle,
  output lfk_pkg::sc_t                       sin_q,
  output lfk_pkg::sc_t                       cos_q
);

  localparam int SW = lfk_pkg::SC_W;
  localparam int ZW = lfk_pkg::Z_W;

  logic signed [SW-1:0] x_r [0:STAGES];
  logic signed [SW-1:0] y_r [0:STAGES];
  logic signed [ZW-1:0] z_r [0:STAGES];
  logic                 flip_r [0:STAGES];
  logic signed [SW-1:0] sin_r, cos_r;

  logic        flip_nxt;
  logic [31:0] t_nxt;

  // second and third quarter turn move by half a turn
  always_comb begin
    flip_nxt = (angle[31:30] == 2'b01) || (angle[31:30] == 2'b10);
    t_nxt    = flip_nxt ? (angle ^ 32'h8000_0000) : angle;
  end

  always_ff @(posedge clk) begin
    x_r[0]    <= SW'(lfk_pkg::GAIN_Q16);
    y_r[0]    <= '0;
    z_r[0]    <= {{(ZW-32){t_nxt[31]}}, t_nxt};
    flip_r[0] <= flip_nxt;
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [ZW-1:0] ATAN = ZW'(lfk_pkg::atan_turn(i));
    always_ff @(posedge clk) begin
      if (!z_r[i][ZW-1]) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - ATAN;
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + ATAN;
      end
      flip_r[i+1] <= flip_r[i];
    end
  end

  always_ff @(posedge clk) begin
    sin_r <= flip_r[STAGES] ? -y_r[STAGES] : y_r[STAGES];
    cos_r <= flip_r[STAGES] ? -x_r[STAGES] : x_r[STAGES];
  end

  assign sin_q = sin_r;
  assign cos_q = cos_r;

endmodule

`default_nettype wire

// ===== rtl/core/leg_forward_kinematics.sv =====
// top level of the three-joint leg forward kinematics pipeline
// depends on lfk_pkg and lfk_cordic
`default_nettype none

// usage
//   input channel: a word of three joint angles (pitch, hip, knee) is taken at
//   each rising edge where start is high and busy is low; busy is always low,
//   so one word can enter every cycle
//   result channel: foot_x, foot_y, foot_z appear for one cycle with out_valid
//   high; the receiver cannot stall, so nothing is held back
//   configuration: cfg_we writes cfg_wdata into register cfg_index
//   (0 base offset, 1 upper link, 2 lower link); other indexes are ignored;
//   write only while no word is in flight
// pipeline and throughput
//   one word per cycle; the depth is set by the unrolled cordic (one iteration per stage)
//   plus product, sum, final product and rounding stages
// reset
//   synchronous active-low reset clears the valid bits and link lengths;
//   data registers carry no reset

module leg_forward_kinematics #(
  parameter int ANGLE_BITS    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output      logic                        busy,
  input  wire logic signed [15:0]          in_pitch_angle,
  input  wire logic signed [15:0]          in_hip_angle,
  input  wire logic signed [15:0]          in_knee_angle,
  output      logic                        out_valid,
  output      logic signed [17:0]          out_foot_x,
  output      logic signed [17:0]          out_foot_y,
  output      logic signed [17:0]          out_foot_z,
  input  wire logic                        cfg_we,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [14:0]                 cfg_wdata
);

  localparam int DEPTH = CORDIC_STAGES + 6;
  localparam logic [31:0] AMASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);

  // link length registers
  logic [14:0] len0_r, len1_r, len2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len0_r <= '0;
      len1_r <= '0;
      len2_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        lfk_pkg::REG_BASE:  len0_r <= cfg_wdata;
        lfk_pkg::REG_UPPER: len1_r <= cfg_wdata;
        lfk_pkg::REG_LOWER: len2_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // never blocks; results cannot be held off
  assign busy = 1'b0;

  // valid bits travel alongside the data
  logic [DEPTH-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[DEPTH-2:0], start & ~busy};
    end
  end

  // binary angle to a 32-bit turn, with hip+knee wrapping mod a turn
  function automatic logic [31:0] to_turn(input logic [15:0] a);
    logic [31:0] ext;
    ext = {{16{a[15]}}, a} & AMASK;
    return ext << (32 - ANGLE_BITS);
  endfunction

  logic [31:0] t_pitch, t_hip, t_sum;
  always_comb begin
    t_pitch = to_turn(in_pitch_angle);
    t_hip   = to_turn(in_hip_angle);
    t_sum   = t_hip + to_turn(in_knee_angle);
  end

  lfk_pkg::sc_t s0, c0, s1, c1, s12, c12;

  lfk_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_pitch (
    .clk(clk), .angle(t_pitch), .sin_q(s0), .cos_q(c0));
  lfk_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_hip (
    .clk(clk), .angle(t_hip), .sin_q(s1), .cos_q(c1));
  lfk_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_sum (
    .clk(clk), .angle(t_sum), .sin_q(s12), .cos_q(c12));

  // stage m1: link products
  logic signed [35:0] p1s_r, p2s_r, p1c_r, p2c_r;
  logic signed [19:0] s0_m1_r, nc0_m1_r;
  always_ff @(posedge clk) begin
    p1s_r    <= $signed({1'b0, len1_r}) * s1;
    p2s_r    <= $signed({1'b0, len2_r}) * s12;
    p1c_r    <= $signed({1'b0, len1_r}) * c1;
    p2c_r    <= $signed({1'b0, len2_r}) * c12;
    s0_m1_r  <= s0;
    nc0_m1_r <= -c0;
  end

  // stage m2: horizontal reach and forward offset, both q16
  logic signed [36:0] px_r;
  logic signed [37:0] reach_r;
  logic signed [19:0] s0_m2_r, nc0_m2_r;
  always_ff @(posedge clk) begin
    px_r     <= 37'(p1s_r) + 37'(p2s_r);
    reach_r  <= $signed({7'd0, len0_r, 16'd0}) + 38'(p1c_r) + 38'(p2c_r);
    s0_m2_r  <= s0_m1_r;
    nc0_m2_r <= nc0_m1_r;
  end

  // stage m3: pitch products in q32, x rounded
  logic signed [57:0] py_r, pz_r;
  logic [17:0] fx_m3_r;
  logic signed [36:0] px_rnd;
  always_comb begin
    px_rnd = (px_r + 37'sd32768) >>> 16;
  end
  always_ff @(posedge clk) begin
    py_r    <= s0_m2_r * reach_r;
    pz_r    <= nc0_m2_r * reach_r;
    fx_m3_r <= lfk_pkg::sat_out(32'(px_rnd));
  end

  // stage m4: round y and z half up
  logic signed [57:0] py_rnd, pz_rnd;
  logic [17:0] fx_r, fy_r, fz_r;
  always_comb begin
    py_rnd = (py_r + 58'sh8000_0000) >>> 32;
    pz_rnd = (pz_r + 58'sh8000_0000) >>> 32;
  end
  always_ff @(posedge clk) begin
    fx_r <= fx_m3_r;
    fy_r <= lfk_pkg::sat_out(32'(py_rnd));
    fz_r <= lfk_pkg::sat_out(32'(pz_rnd));
  end

  assign out_valid  = vld_r[DEPTH-1];
  assign out_foot_x = fx_r;
  assign out_foot_y = fy_r;
  assign out_foot_z = fz_r;

  // an accepted word enters the valid chain on the next edge
  a_vld_entry: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (vld_r[0] == $past(start)))
    else $error("valid chain entry mismatch");

  // strobe follows the valid chain: out_valid is the registered copy of its second-to-last bit
  a_vld_exit: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (out_valid == $past(vld_r[DEPTH-2])))
    else $error("result strobe misaligned");

  // pitch sine and summed-angle cosine of a live word stay near unit magnitude
  a_sin_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[CORDIC_STAGES+1] |->
      ((s0 < 20'sd70000) && (s0 > -20'sd70000) &&
       (c12 < 20'sd70000) && (c12 > -20'sd70000)))
    else $error("cordic output out of range");

endmodule

`default_nettype wire
